// ===== rtl/stag_pkg.sv =====
// ----------------------------------------------------------------------------
// stag_pkg
// Shared types and codes of the strided tensor address generator.
// ----------------------------------------------------------------------------
package stag_pkg;

   localparam int EXTENT_W  = 31;
   localparam int WORD_W    = 32;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 4;
   localparam int FIELD_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIMS     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_OPERANDS = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_START   = 2'd1,
      OP_ADVANCE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_EMIT,
      ST_UPDATE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      op_type                kind;
      logic [FIELD_W-1:0]    dim_index;
      logic [FIELD_W-1:0]    operand_index;
      logic [EXTENT_W-1:0]   extent;
      logic [WORD_W-1:0]     stride;
      logic [WORD_W-1:0]     base_offset;
   } cmd_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CFG_W-1:0]      data;
   } csr_wr_type;

endpackage

// ===== rtl/stag_ram.sv =====
// ----------------------------------------------------------------------------
// stag_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module stag_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/stag_front.sv =====
// ----------------------------------------------------------------------------
// stag_front
// Input side: decodes request words, drops out-of-range and undefined ones,
// and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module stag_front import stag_pkg::*; #(
   parameter int MAX_DIMS = 8,
   parameter int MAX_OPS  = 8
) (
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [2:0]          req_dim_index,
   input  logic [2:0]          req_operand_index,
   input  logic [30:0]         req_extent,
   input  logic signed [31:0]  req_stride,
   input  logic [31:0]         req_base_offset,
   input  logic                queue_full,
   output logic                push,
   output cmd_type             push_cmd
);

   logic dim_ok;
   logic opnd_ok;
   logic keep;

   always_comb begin
      dim_ok  = 32'(req_dim_index) < 32'(MAX_DIMS);
      opnd_ok = 32'(req_operand_index) < 32'(MAX_OPS);
      case (op_type'(req_op))
         OP_LOAD: begin
            keep = dim_ok && opnd_ok;
         end
         OP_START: begin
            keep = opnd_ok;
         end
         OP_ADVANCE: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      push_cmd.kind          = op_type'(req_op);
      push_cmd.dim_index     = req_dim_index;
      push_cmd.operand_index = req_operand_index;
      push_cmd.extent        = req_extent;
      push_cmd.stride        = $unsigned(req_stride);
      push_cmd.base_offset   = req_base_offset;
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full && keep;

endmodule

// ===== rtl/stag_queue.sv =====
// ----------------------------------------------------------------------------
// stag_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module stag_queue import stag_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    not_empty
);

   cmd_type    slot_ff [2];
   cmd_type    slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      slot_in   = push_cmd;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);

endmodule

// ===== rtl/stag_back.sv =====
// ----------------------------------------------------------------------------
// stag_back
// Execution side: descriptor tables, odometer, per-operand offsets, the
// stride-times-extent update pipeline and the result register.
// ----------------------------------------------------------------------------
module stag_back import stag_pkg::*; #(
   parameter int MAX_DIMS = 8,
   parameter int MAX_OPS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  csr_wr_type  csr_wr,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_out_operand,
   output logic [31:0] rsp_offset,
   output logic        rsp_last,
   output logic        rsp_wrapped
);

   localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int OPI_W  = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
   localparam int ND_W   = $clog2(MAX_DIMS + 1);
   localparam int NO_W   = $clog2(MAX_OPS + 1);
   localparam int SDEPTH = MAX_OPS * MAX_DIMS;
   localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     num_dims_ff, num_dims_in;
   logic [CFG_W-1:0]     num_ops_ff, num_ops_in;
   logic [EXTENT_W-1:0]  extent_ff [MAX_DIMS];
   logic [EXTENT_W-1:0]  extent_in [MAX_DIMS];
   logic [EXTENT_W-1:0]  coord_ff [MAX_DIMS];
   logic [EXTENT_W-1:0]  coord_in [MAX_DIMS];
   logic [WORD_W-1:0]    offset_ff [MAX_OPS];
   logic [WORD_W-1:0]    offset_in [MAX_OPS];
   logic [DIM_W-1:0]     stop_ff, stop_in;
   logic                 wrapped_ff, wrapped_in;
   logic [OPI_W-1:0]     emit_idx_ff, emit_idx_in;
   logic [DIM_W-1:0]     upd_dim_ff, upd_dim_in;
   logic [OPI_W-1:0]     upd_op_ff, upd_op_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic [OPI_W-1:0]     s1_op_ff, s1_op_in;
   logic [WORD_W-1:0]    s1_factor_ff, s1_factor_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic [OPI_W-1:0]     s2_op_ff, s2_op_in;
   logic [WORD_W-1:0]    s2_prod_ff, s2_prod_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_operand_ff, rsp_operand_in;
   logic [WORD_W-1:0]    rsp_offset_ff, rsp_offset_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_wrapped_ff, rsp_wrapped_in;

   logic [ND_W-1:0]      nd;
   logic [NO_W-1:0]      no;
   logic [DIM_W-1:0]     nd_last;
   logic [OPI_W-1:0]     no_last;
   logic [DIM_W-1:0]     end_dim;
   logic [EXTENT_W-1:0]  coord_inc [MAX_DIMS];
   logic [EXTENT_W-1:0]  coord_step [MAX_DIMS];
   logic [MAX_DIMS-1:0]  inc_ok;
   logic                 found;
   logic [DIM_W-1:0]     stop_sel;
   logic [OPI_W-1:0]     off_rd_idx;
   logic [WORD_W-1:0]    off_rd;

   logic                 ram_wr_en;
   logic [SA_W-1:0]      ram_wr_addr;
   logic                 ram_rd_en;
   logic [SA_W-1:0]      ram_rd_addr;
   logic [WORD_W-1:0]    ram_rd_data;

   stag_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SDEPTH)
   ) u_stride_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (q_cmd.stride),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // active counts, saturated to the supported range
   always_comb begin
      if (num_dims_ff == '0) begin
         nd = ND_W'(1);
      end else if (32'(num_dims_ff) > 32'(MAX_DIMS)) begin
         nd = ND_W'(MAX_DIMS);
      end else begin
         nd = ND_W'(num_dims_ff);
      end
      if (num_ops_ff == '0) begin
         no = NO_W'(1);
      end else if (32'(num_ops_ff) > 32'(MAX_OPS)) begin
         no = NO_W'(MAX_OPS);
      end else begin
         no = NO_W'(num_ops_ff);
      end
      nd_last = DIM_W'(nd - ND_W'(1));
      no_last = OPI_W'(no - NO_W'(1));
      end_dim = wrapped_ff ? '0 : stop_ff;
   end

   // odometer step: innermost dimension that can still count up stops the carry
   always_comb begin
      found    = 1'b0;
      stop_sel = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         coord_inc[d] = coord_ff[d] + 31'd1;
         inc_ok[d]    = (d < int'(nd)) && (coord_inc[d] < extent_ff[d]);
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (inc_ok[d]) begin
            found    = 1'b1;
            stop_sel = DIM_W'(d);
         end
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         coord_step[d] = coord_ff[d];
         if (d < int'(nd)) begin
            if (found && (DIM_W'(d) == stop_sel)) begin
               coord_step[d] = coord_inc[d];
            end else if (!found || (DIM_W'(d) > stop_sel)) begin
               coord_step[d] = '0;
            end
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      num_dims_in    = num_dims_ff;
      num_ops_in     = num_ops_ff;
      extent_in      = extent_ff;
      coord_in       = coord_ff;
      offset_in      = offset_ff;
      stop_in        = stop_ff;
      wrapped_in     = wrapped_ff;
      emit_idx_in    = emit_idx_ff;
      upd_dim_in     = upd_dim_ff;
      upd_op_in      = upd_op_ff;
      s1_valid_in    = 1'b0;
      s1_op_in       = upd_op_ff;
      s1_factor_in   = 32'd1 - {1'b0, extent_ff[upd_dim_ff]};
      if ((upd_dim_ff == stop_ff) && !wrapped_ff) begin
         s1_factor_in = 32'd1;
      end
      s2_valid_in    = s1_valid_ff;
      s2_op_in       = s1_op_ff;
      s2_prod_in     = s1_factor_ff * ram_rd_data;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_operand_in = rsp_operand_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_wrapped_in = rsp_wrapped_ff;
      q_pop          = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = SA_W'(q_cmd.operand_index) * SA_W'(MAX_DIMS)
                     + SA_W'(q_cmd.dim_index);
      ram_rd_en      = 1'b0;
      ram_rd_addr    = SA_W'(upd_op_ff) * SA_W'(MAX_DIMS) + SA_W'(upd_dim_ff);

      off_rd_idx = (state_ff == ST_EMIT) ? emit_idx_ff : s2_op_ff;
      off_rd     = offset_ff[off_rd_idx];
      if (s2_valid_ff) begin
         offset_in[s2_op_ff] = off_rd + s2_prod_ff;
      end

      if (csr_wr.valid) begin
         case (csr_wr.index)
            CSR_NUM_DIMS: begin
               num_dims_in = csr_wr.data;
            end
            CSR_NUM_OPERANDS: begin
               num_ops_in = csr_wr.data;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  OP_LOAD: begin
                     extent_in[DIM_W'(q_cmd.dim_index)] = q_cmd.extent;
                     ram_wr_en = 1'b1;
                  end
                  OP_START: begin
                     offset_in[OPI_W'(q_cmd.operand_index)] = q_cmd.base_offset;
                     coord_in = '{default: '0};
                  end
                  OP_ADVANCE: begin
                     state_in = ST_CLASSIFY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLASSIFY: begin
            coord_in    = coord_step;
            stop_in     = stop_sel;
            wrapped_in  = !found;
            emit_idx_in = '0;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_operand_in = 3'(emit_idx_ff);
               rsp_offset_in  = off_rd;
               rsp_last_in    = (emit_idx_ff == no_last);
               rsp_wrapped_in = wrapped_ff;
               if (emit_idx_ff == no_last) begin
                  upd_dim_in = nd_last;
                  upd_op_in  = '0;
                  state_in   = ST_UPDATE;
               end else begin
                  emit_idx_in = emit_idx_ff + OPI_W'(1);
               end
            end
         end
         ST_UPDATE: begin
            ram_rd_en   = 1'b1;
            s1_valid_in = 1'b1;
            if (upd_op_ff == no_last) begin
               upd_op_in = '0;
               if (upd_dim_ff == end_dim) begin
                  state_in = ST_DRAIN;
               end else begin
                  upd_dim_in = upd_dim_ff - DIM_W'(1);
               end
            end else begin
               upd_op_in = upd_op_ff + OPI_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff  <= CFG_W'(1);
         num_ops_ff   <= CFG_W'(1);
         coord_ff     <= '{default: '0};
         offset_ff    <= '{default: '0};
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_dims_ff  <= num_dims_in;
         num_ops_ff   <= num_ops_in;
         coord_ff     <= coord_in;
         offset_ff    <= offset_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      extent_ff      <= extent_in;
      stop_ff        <= stop_in;
      wrapped_ff     <= wrapped_in;
      emit_idx_ff    <= emit_idx_in;
      upd_dim_ff     <= upd_dim_in;
      upd_op_ff      <= upd_op_in;
      s1_op_ff       <= s1_op_in;
      s1_factor_ff   <= s1_factor_in;
      s2_op_ff       <= s2_op_in;
      s2_prod_ff     <= s2_prod_in;
      rsp_operand_ff <= rsp_operand_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_wrapped_ff <= rsp_wrapped_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_operand = rsp_operand_ff;
   assign rsp_offset      = rsp_offset_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_wrapped     = rsp_wrapped_ff;

endmodule

// ===== rtl/strided_tensor_address_generator.sv =====
// ----------------------------------------------------------------------------
// strided_tensor_address_generator
// Walks up to MAX_OPS operand tensors of one shape over up to MAX_DIMS
// dimensions and returns each operand's element offset on every advance.
//
//   channel  dir  handshake           word
//   req      in   req_valid/stall     op, dim/operand index, extent, stride, base
//   rsp      out  rsp_valid/stall     operand, offset, last, wrapped
//   csr      in   csr_valid/ready     register index, data
//
// Descriptor loads and base sets pass through the queue, then the back end.
// An advance emits one result word per active operand, then updates each
// operand's offset for every updated dimension (the wrapped ones plus the one
// that counts up, all of them on a full wrap), one stride multiply per cycle
// through the single stride RAM read port. A stalled result holds the emit
// step. The two-entry queue accepts requests until full while the back end works.
// Reset is synchronous; coordinates and offsets clear at once.
// ----------------------------------------------------------------------------
module strided_tensor_address_generator import stag_pkg::*; #(
   parameter int MAX_DIMS = 8,
   parameter int MAX_OPS  = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [2:0]          req_dim_index,
   input  logic [2:0]          req_operand_index,
   input  logic [30:0]         req_extent,
   input  logic signed [31:0]  req_stride,
   input  logic [31:0]         req_base_offset,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_out_operand,
   output logic [31:0]         rsp_offset,
   output logic                rsp_last,
   output logic                rsp_wrapped,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_index,
   input  logic [3:0]          csr_data
);

   logic       push;
   cmd_type    push_cmd;
   logic       queue_full;
   logic       q_valid;
   logic       q_pop;
   cmd_type    q_cmd;
   csr_wr_type csr_wr;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   stag_front #(
      .MAX_DIMS (MAX_DIMS),
      .MAX_OPS  (MAX_OPS)
   ) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_dim_index     (req_dim_index),
      .req_operand_index (req_operand_index),
      .req_extent        (req_extent),
      .req_stride        (req_stride),
      .req_base_offset   (req_base_offset),
      .queue_full        (queue_full),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   stag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_cmd   (q_cmd),
      .not_empty (q_valid)
   );

   stag_back #(
      .MAX_DIMS (MAX_DIMS),
      .MAX_OPS  (MAX_OPS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr          (csr_wr),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_operand (rsp_out_operand),
      .rsp_offset      (rsp_offset),
      .rsp_last        (rsp_last),
      .rsp_wrapped     (rsp_wrapped)
   );

endmodule

// ===== rtl/stag_checker.sv =====
// ----------------------------------------------------------------------------
// stag_checker
// Port-level checks on the result stream of the address generator.
// ----------------------------------------------------------------------------
module stag_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_out_operand,
   input logic       rsp_last,
   input logic       rsp_wrapped
);

   logic [2:0] exp_op_ff, exp_op_in;
   logic       wrap_ff, wrap_in;

   always_comb begin
      exp_op_in = exp_op_ff;
      wrap_in   = wrap_ff;
      if (rsp_valid && !rsp_stall) begin
         exp_op_in = rsp_last ? 3'd0 : exp_op_ff + 3'd1;
         wrap_in   = rsp_wrapped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_op_ff <= 3'd0;
      end else begin
         exp_op_ff <= exp_op_in;
      end
   end

   always_ff @(posedge clock) begin
      wrap_ff <= wrap_in;
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_operand)
                                 && $stable(rsp_last))
      else $error("stalled result word changed");

   a_operand_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_operand == exp_op_ff)
      else $error("operand words out of order");

   a_wrap_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (exp_op_ff != 3'd0) |-> rsp_wrapped == wrap_ff)
      else $error("wrapped flag changed within one advance");

endmodule

bind strided_tensor_address_generator stag_checker u_stag_checker (.*);
